// ----- hw/rtl/ptd_pkg.sv -----
// Shared types and constants for the point-to-depth-image projector.
// No dependencies; imported by every module of the block.
package ptd_pkg;

  // Frame geometry
  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;
  localparam int FRAME_DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W       = $clog2(FRAME_DEPTH);

  // Field widths
  localparam int COORD_W = 32;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 9;
  localparam int DEPTH_W = 31;
  localparam int MAG_W   = 63;   // |h| * focal fits in 63 bits
  localparam int CFG_IDX_W = 3;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Input action codes
  localparam logic [1:0] ACT_PROJECT = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIDAR_MODE = 3'd4;

  typedef struct packed {
    logic [1:0]                action;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [COL_W-1:0]          read_col;
    logic [ROW_W-1:0]          read_row;
  } point_t;

  typedef struct packed {
    logic               hit;
    logic [COL_W-1:0]   pixel_col;
    logic [ROW_W-1:0]   pixel_row;
    logic [DEPTH_W-1:0] depth_value;
  } result_t;

  typedef struct packed {
    logic [31:0] focal_x;
    logic [31:0] focal_y;
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic        lidar_mode;
  } cfg_t;

  // Classified work for the back end
  typedef enum logic [1:0] {
    CMD_PROJECT,
    CMD_READ,
    CMD_CLEAR,
    CMD_NONE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic               neg_c;
    logic               neg_r;
    logic [MAG_W-1:0]   mag_c;
    logic [MAG_W-1:0]   mag_r;
    logic [DEPTH_W-1:0] depth;
    logic [COL_W-1:0]   read_col;
    logic [ROW_W-1:0]   read_row;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

endpackage

// ----- hw/rtl/point_to_depth_image_projector_top.sv -----
// Top level of the point-to-depth-image projector: config registers and wiring.
// Depends on ptd_pkg, ptd_front, ptd_queue, ptd_back.
// A project word runs 63 radix-2 divide steps, both axes at once; a clear word zeroes one store
// entry per cycle. The back end takes one word at a time; the divider loop sets the point rate.
// Reset: synchronous; registers take their defaults and the store is swept to zero,
// during which no word is accepted.
module point_to_depth_image_projector_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              point_valid,
  output logic                              point_ready,
  input  ptd_pkg::point_t                   point,
  output logic                              result_valid,
  input  logic                              result_ready,
  output ptd_pkg::result_t                  result,
  input  logic                              cfg_we,
  input  logic [ptd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);
  import ptd_pkg::*;

  cfg_t       cfg;
  back_stat_t stat;
  logic       f_valid, f_ready, q_valid, q_ready;
  cmd_t       f_cmd, q_cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_x    <= 32'd36323652;
      cfg.focal_y    <= 32'd36323652;
      cfg.center_x   <= 32'd21004288;
      cfg.center_y   <= 32'd15761408;
      cfg.lidar_mode <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FOCAL_X:    cfg.focal_x    <= cfg_data;
        REG_FOCAL_Y:    cfg.focal_y    <= cfg_data;
        REG_CENTER_X:   cfg.center_x   <= cfg_data;
        REG_CENTER_Y:   cfg.center_y   <= cfg_data;
        REG_LIDAR_MODE: cfg.lidar_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  ptd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .stat        (stat),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .point       (point),
    .cmd_valid   (f_valid),
    .cmd_ready   (f_ready),
    .cmd         (f_cmd)
  );

  ptd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  ptd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .stat         (stat),
    .cmd_valid    (q_valid),
    .cmd_ready    (q_ready),
    .cmd          (q_cmd),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ----- hw/rtl/ptd_front.sv -----
// Front end: accepts point words, picks axes, forms focal products.
// Depends on ptd_pkg.
module ptd_front (
  input  logic               clk,
  input  logic               rst,
  input  ptd_pkg::cfg_t      cfg,
  input  ptd_pkg::back_stat_t stat,
  input  logic               point_valid,
  output logic               point_ready,
  input  ptd_pkg::point_t    point,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output ptd_pkg::cmd_t      cmd
);
  import ptd_pkg::*;

  logic [COORD_W-1:0] h, v, d;
  logic [COORD_W-1:0] mag_h, mag_v;
  logic [63:0]        prod_c, prod_r;
  logic               d_pos;
  cmd_t               cmd_next;

  assign point_ready = (!cmd_valid || cmd_ready) && !stat.init_busy;

  // Axis selection and magnitude products
  always_comb begin
    if (cfg.lidar_mode) begin
      h = point.coord_y;
      v = point.coord_z;
      d = point.coord_x;
    end else begin
      h = point.coord_x;
      v = point.coord_y;
      d = point.coord_z;
    end
    mag_h  = h[COORD_W-1] ? (~h + 1'b1) : h;
    mag_v  = v[COORD_W-1] ? (~v + 1'b1) : v;
    prod_c = 64'(mag_h) * 64'(cfg.focal_x);
    prod_r = 64'(mag_v) * 64'(cfg.focal_y);
    d_pos  = !d[COORD_W-1] && (d != '0);

    cmd_next          = '0;
    cmd_next.neg_c    = h[COORD_W-1];
    cmd_next.neg_r    = v[COORD_W-1];
    cmd_next.mag_c    = prod_c[MAG_W-1:0];
    cmd_next.mag_r    = prod_r[MAG_W-1:0];
    cmd_next.depth    = d[DEPTH_W-1:0];
    cmd_next.read_col = point.read_col;
    cmd_next.read_row = point.read_row;
    case (point.action)
      ACT_PROJECT: cmd_next.kind = d_pos ? CMD_PROJECT : CMD_NONE;
      ACT_READ:    cmd_next.kind = CMD_READ;
      ACT_CLEAR:   cmd_next.kind = CMD_CLEAR;
      default:     cmd_next.kind = CMD_NONE;
    endcase
  end

  // Output stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (point_valid && point_ready) begin
      cmd_valid <= 1'b1;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
    if (point_valid && point_ready) begin
      cmd <= cmd_next;
    end
  end

endmodule

// ----- hw/rtl/ptd_queue.sv -----
// Short command queue decoupling front and back ends.
// Depends on ptd_pkg.
module ptd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  ptd_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output ptd_pkg::cmd_t pop_cmd
);
  import ptd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t               entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [PTR_W:0]     count;
  logic               do_push, do_pop;

  assign push_ready = (count != (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- hw/rtl/ptd_back.sv -----
// Back end: divider sequencer, range check, depth frame store, result register.
// Depends on ptd_pkg.
module ptd_back (
  input  logic                clk,
  input  logic                rst,
  input  ptd_pkg::cfg_t       cfg,
  output ptd_pkg::back_stat_t stat,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  ptd_pkg::cmd_t       cmd,
  output logic                result_valid,
  input  logic                result_ready,
  output ptd_pkg::result_t    result
);
  import ptd_pkg::*;

  localparam int SUM_W     = 65;
  localparam int DIV_STEPS = MAG_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam logic signed [SUM_W-1:0] SUM_LO = -65'sd65536;
  localparam logic signed [SUM_W-1:0] COL_HI = SUM_W'(FRAME_WIDTH * 65536);
  localparam logic signed [SUM_W-1:0] ROW_HI = SUM_W'(FRAME_HEIGHT * 65536);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DIV, S_SUM, S_CHECK, S_WRITE, S_READ, S_RWAIT, S_CLEAR, S_DONE
  } state_t;

  state_t                    state;
  logic [CNT_W-1:0]          cnt;
  logic [MAG_W-1:0]          dvd_c, dvd_r;
  logic [DEPTH_W-1:0]        rem_c, rem_r;
  logic                      neg_c, neg_r;
  logic [DEPTH_W-1:0]        dval;
  logic signed [SUM_W-1:0]   sum_c, sum_r;
  logic [COL_W-1:0]          col;
  logic [ROW_W-1:0]          row;
  logic [ADDR_W-1:0]         addr;
  result_t                   res;

  logic [DEPTH_W-1:0]        mem [FRAME_DEPTH];
  logic [DEPTH_W-1:0]        mem_q;
  logic [ADDR_W-1:0]         mem_addr;
  logic                      mem_we;
  logic [DEPTH_W-1:0]        mem_wdata;

  logic [DEPTH_W:0]          rs_c, rs_r;
  logic                      ge_c, ge_r;
  logic signed [63:0]        q_c, q_r;
  logic                      in_c, in_r, out_free;
  logic [COL_W-1:0]          col_next;
  logic [ROW_W-1:0]          row_next;

  assign stat.init_busy = (state == S_INIT);
  assign cmd_ready      = (state == S_IDLE);
  assign out_free       = !result_valid || result_ready;

  // One restoring divide step per cycle on both axes
  always_comb begin
    rs_c = {rem_c, dvd_c[MAG_W-1]};
    rs_r = {rem_r, dvd_r[MAG_W-1]};
    ge_c = rs_c >= {1'b0, dval};
    ge_r = rs_r >= {1'b0, dval};
  end

  // Signed quotients
  always_comb begin
    q_c = neg_c ? -$signed({1'b0, dvd_c}) : $signed({1'b0, dvd_c});
    q_r = neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});
  end

  // Frame bounds and pixel coordinates, truncating toward zero
  always_comb begin
    in_c     = (sum_c > SUM_LO) && (sum_c < COL_HI);
    in_r     = (sum_r > SUM_LO) && (sum_r < ROW_HI);
    col_next = sum_c[SUM_W-1] ? '0 : sum_c[16 +: COL_W];
    row_next = sum_r[SUM_W-1] ? '0 : sum_r[16 +: ROW_W];
    if (cfg.lidar_mode) begin
      row_next = ROW_W'(FRAME_HEIGHT - 1) - row_next;
    end
  end

  // Store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    mem_addr  = addr;
    case (state)
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = dval;
        mem_addr  = ADDR_W'(row) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(col);
      end
      S_INIT, S_CLEAR: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Depth frame store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_q <= mem[mem_addr];
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      addr         <= '0;
      result_valid <= 1'b0;
    end else begin
      // a word leaving in S_DONE is replaced there
      if (result_valid && result_ready && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          addr <= addr + 1'b1;
          if (addr == ADDR_W'(FRAME_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            res <= '0;
            case (cmd.kind)
              CMD_PROJECT: begin
                dvd_c <= cmd.mag_c;
                dvd_r <= cmd.mag_r;
                rem_c <= '0;
                rem_r <= '0;
                neg_c <= cmd.neg_c;
                neg_r <= cmd.neg_r;
                dval  <= cmd.depth;
                cnt   <= '0;
                state <= S_DIV;
              end
              CMD_READ: begin
                if (32'(cmd.read_col) < FRAME_WIDTH && 32'(cmd.read_row) < FRAME_HEIGHT) begin
                  addr  <= ADDR_W'(cmd.read_row) * ADDR_W'(FRAME_WIDTH)
                           + ADDR_W'(cmd.read_col);
                  state <= S_READ;
                end else begin
                  state <= S_DONE;
                end
              end
              CMD_CLEAR: begin
                addr  <= '0;
                state <= S_CLEAR;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_DIV: begin
          rem_c <= ge_c ? DEPTH_W'(rs_c - {1'b0, dval}) : DEPTH_W'(rs_c);
          rem_r <= ge_r ? DEPTH_W'(rs_r - {1'b0, dval}) : DEPTH_W'(rs_r);
          dvd_c <= {dvd_c[MAG_W-2:0], ge_c};
          dvd_r <= {dvd_r[MAG_W-2:0], ge_r};
          cnt   <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          sum_c <= SUM_W'(q_c) + $signed({33'd0, cfg.center_x});
          sum_r <= SUM_W'(q_r) + $signed({33'd0, cfg.center_y});
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (in_c && in_r) begin
            col             <= col_next;
            row             <= row_next;
            res.hit         <= 1'b1;
            res.pixel_col   <= col_next;
            res.pixel_row   <= row_next;
            res.depth_value <= dval;
            state           <= S_WRITE;
          end else begin
            state <= S_DONE;
          end
        end
        S_WRITE: begin
          state <= S_DONE;
        end
        S_READ: begin
          state <= S_RWAIT;
        end
        S_RWAIT: begin
          res.depth_value <= mem_q;
          state           <= S_DONE;
        end
        S_CLEAR: begin
          addr <= addr + 1'b1;
          if (addr == ADDR_W'(FRAME_DEPTH - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            result       <= res;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A stored hit always carries a positive depth
  a_hit_depth: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.hit |-> result.depth_value != '0)
    else $error("hit result with zero depth");

  // Misses, reads and clears report no pixel
  a_miss_pixel: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.hit |-> result.pixel_col == '0 && result.pixel_row == '0)
    else $error("non-hit result with pixel coordinates");

  // Hit pixels lie inside the frame
  a_hit_bounds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.hit |->
      32'(result.pixel_col) < FRAME_WIDTH && 32'(result.pixel_row) < FRAME_HEIGHT)
    else $error("hit pixel outside frame");

  // Divider leaves after its last step
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && cnt == CNT_W'(DIV_STEPS - 1) |=> state == S_SUM)
    else $error("divider step count slip");

endmodule

// ----- test/ptd_checker.sv -----
// Scoreboard for the point-to-depth-image projector: watches the word and config ports,
// predicts each result with its own projection model and frame store, and counts errors.
// Depends on ptd_pkg.
`timescale 1ns / 100ps

module ptd_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             point_valid,
  input  logic             point_ready,
  input  ptd_pkg::point_t  point,
  input  logic             result_valid,
  input  logic             result_ready,
  input  ptd_pkg::result_t result,
  input  logic             cfg_we,
  input  logic [ptd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]      cfg_data,
  output int               error_count,
  output int               pending_count
);
  import ptd_pkg::*;

  cfg_t                     cam_cfg;
  logic [DEPTH_W-1:0]       depth_store [int];
  result_t                  expected_results [$];

  // trunc((trunc(h*f/d) + c) / 65536)
  function automatic longint project_axis(longint h, logic [31:0] f, logic [31:0] c,
                                          longint d);
    longint prod;
    longint quot;
    longint sum;
    prod = h * longint'({32'b0, f});
    quot = prod / d;
    sum  = quot + longint'({32'b0, c});
    return sum / 65536;
  endfunction

  // Expected result of one word; updates the frame store
  function automatic result_t predict_pixel(point_t p);
    result_t r;
    longint  hh;
    longint  vv;
    longint  dd;
    longint  col;
    longint  row;
    r = '0;
    case (p.action)
      ACT_PROJECT: begin
        if (cam_cfg.lidar_mode) begin
          hh = p.coord_y; vv = p.coord_z; dd = p.coord_x;
        end else begin
          hh = p.coord_x; vv = p.coord_y; dd = p.coord_z;
        end
        if (dd > 0) begin
          col = project_axis(hh, cam_cfg.focal_x, cam_cfg.center_x, dd);
          row = project_axis(vv, cam_cfg.focal_y, cam_cfg.center_y, dd);
          if (col >= 0 && col < FRAME_WIDTH && row >= 0 && row < FRAME_HEIGHT) begin
            if (cam_cfg.lidar_mode) row = FRAME_HEIGHT - 1 - row;
            depth_store[int'(row * FRAME_WIDTH + col)] = dd[DEPTH_W-1:0];
            r.hit         = 1'b1;
            r.pixel_col   = col[COL_W-1:0];
            r.pixel_row   = row[ROW_W-1:0];
            r.depth_value = dd[DEPTH_W-1:0];
          end
        end
      end
      ACT_READ: begin
        if (p.read_col < FRAME_WIDTH && p.read_row < FRAME_HEIGHT &&
            depth_store.exists(int'(p.read_row) * FRAME_WIDTH + int'(p.read_col)))
          r.depth_value = depth_store[int'(p.read_row) * FRAME_WIDTH + int'(p.read_col)];
      end
      ACT_CLEAR: depth_store.delete();
      default: ;
    endcase
    return r;
  endfunction

  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      cam_cfg <= '{32'd36323652, 32'd36323652, 32'd21004288, 32'd15761408, 1'b1};
      depth_store.delete();
      expected_results.delete();
      error_count <= 0;
    end else begin
      // config writes
      if (cfg_we) begin
        case (cfg_index)
          REG_FOCAL_X:    cam_cfg.focal_x    <= cfg_data;
          REG_FOCAL_Y:    cam_cfg.focal_y    <= cfg_data;
          REG_CENTER_X:   cam_cfg.center_x   <= cfg_data;
          REG_CENTER_Y:   cam_cfg.center_y   <= cfg_data;
          REG_LIDAR_MODE: cam_cfg.lidar_mode <= cfg_data[0];
          default: ;
        endcase
      end
      // accepted input word
      if (point_valid && point_ready) expected_results.push_back(predict_pixel(point));
      // accepted result word
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word %p", $realtime, result);
          error_count <= error_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want !== result) begin
            $display("%0t: mismatch: expected hit=%0d col=%0d row=%0d depth=%0d",
                     $realtime, want.hit, want.pixel_col, want.pixel_row, want.depth_value);
            $display("%0t:           actual hit=%0d col=%0d row=%0d depth=%0d",
                     $realtime, result.hit, result.pixel_col, result.pixel_row,
                     result.depth_value);
            error_count <= error_count + 1;
          end
        end
      end
    end
  end
endmodule

// ----- test/tb_top.sv -----
// Testbench top for the point-to-depth-image projector: clock, reset, config phases,
// directed and random point/read/clear words, backpressure. Depends on ptd_pkg, ptd_checker.
`timescale 1ns / 100ps

module tb_top;
  import ptd_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic    clk;
  logic    rst;
  logic    point_valid;
  logic    point_ready;
  point_t  point;
  logic    result_valid;
  logic    result_ready;
  result_t result;
  logic    cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;
  int      error_count;
  int      pending_count;

  int      send_idle_pct;
  int      recv_stall_pct;
  logic    mode_lidar;
  int      words_sent;
  int      hits_seen;
  logic [COL_W+ROW_W-1:0] hit_pixels [$];

  point_to_depth_image_projector_top i_dut (.*);

  ptd_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls
  always @(negedge clk) begin
    result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // remember recent hit pixels so reads find written data
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready && result.hit) begin
      hits_seen++;
      hit_pixels.push_back({result.pixel_col, result.pixel_row});
      if (hit_pixels.size() > 64) void'(hit_pixels.pop_front());
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_word(point_t p);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      point_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    point       <= p;
    point_valid <= 1'b1;
    do @(posedge clk); while (!point_ready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic write_cfg(logic [31:0] fx, logic [31:0] fy, logic [31:0] cx,
                           logic [31:0] cy, logic lidar);
    logic [31:0] vals [5];
    vals = '{fx, fy, cx, cy, {31'b0, lidar}};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      @(negedge clk);
    end
    cfg_we     <= 1'b0;
    mode_lidar = lidar;
  endtask

  // drain before touching registers
  task automatic wait_idle();
    point_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  function automatic point_t make_point(int hh, int vv, int dd, logic [1:0] act);
    point_t p;
    p.action   = act;
    p.read_col = COL_W'($urandom);
    p.read_row = ROW_W'($urandom);
    if (mode_lidar) begin
      p.coord_x = dd; p.coord_y = hh; p.coord_z = vv;
    end else begin
      p.coord_x = hh; p.coord_y = vv; p.coord_z = dd;
    end
    return p;
  endfunction

  function automatic point_t random_word(bit allow_clear);
    point_t p;
    int     kind;
    longint dd;
    logic [COL_W+ROW_W-1:0] px;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      // well-formed point with positive depth
      dd = $urandom_range(16384, 30 * 65536);
      p = make_point(int'(dd * (int'($urandom_range(0, 1200)) - 600) / 1024),
                     int'(dd * (int'($urandom_range(0, 1200)) - 600) / 1024),
                     int'(dd), ACT_PROJECT);
    end else if (kind < 75) begin
      p = make_point($urandom, $urandom, $urandom, ACT_READ);
      if (hit_pixels.size() > 0 && $urandom_range(0, 9) < 7) begin
        px = hit_pixels[$urandom_range(0, hit_pixels.size() - 1)];
        p.read_col = px[COL_W+ROW_W-1:ROW_W];
        p.read_row = px[ROW_W-1:0];
      end
    end else if (kind < 90) begin
      p = make_point($urandom, $urandom, $urandom, ACT_PROJECT);
    end else if (kind < 95) begin
      p = make_point($urandom, $urandom, -int'($urandom_range(0, 65536)), ACT_PROJECT);
    end else begin
      p = make_point($urandom, $urandom, $urandom, ACT_UNUSED);
    end
    if (allow_clear) p.action = ACT_CLEAR;
    return p;
  endfunction

  initial begin
    point_t p;
    rst = 1'b1;
    point_valid = 1'b0;
    point = '0;
    result_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mode_lidar = 1'b1;
    words_sent = 0;
    hits_seen = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // let the reset sweep finish before any word
    while (!point_ready) @(negedge clk);

    // directed words, lidar mode at defaults
    send_word(make_point(0, 0, 65536, ACT_PROJECT));                    // center hit
    send_word(make_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, ACT_PROJECT));
    send_word(make_point(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, ACT_PROJECT));
    send_word(make_point(1000, 1000, 0, ACT_PROJECT));                  // zero depth
    send_word(make_point(1000, 1000, 32'h80000000, ACT_PROJECT));       // negative depth
    send_word(make_point(0, 0, 1, ACT_PROJECT));                        // tiny depth
    send_word(make_point(-36000, 24000, 65536, ACT_PROJECT));           // near left edge
    send_word(make_point(36000, -28000, 65536, ACT_PROJECT));           // near corner
    p = make_point(0, 0, 0, ACT_READ); p.read_col = 320; p.read_row = 239;
    send_word(p);
    p.read_col = 0; p.read_row = 0; send_word(p);
    p.read_col = FRAME_WIDTH - 1; p.read_row = FRAME_HEIGHT - 1; send_word(p);
    p.read_col = '1; p.read_row = '1; send_word(p);                     // out of range
    p.read_col = FRAME_WIDTH; p.read_row = 0; send_word(p);
    p.read_col = 0; p.read_row = FRAME_HEIGHT; send_word(p);
    send_word(make_point($urandom, $urandom, $urandom, ACT_UNUSED));
    send_word(make_point(0, 0, 0, ACT_CLEAR));
    p = make_point(0, 0, 0, ACT_READ); p.read_col = 320; p.read_row = 239;
    send_word(p);
    wait_idle();

    // camera mode, origin at zero: slightly negative sums truncate into column/row 0
    write_cfg(32'd36323652, 32'd36323652, 32'd0, 32'd0, 1'b0);
    send_word(make_point(-1, -1, 32'h7FFFFFFF, ACT_PROJECT));
    send_word(make_point(-100, 5, 65536, ACT_PROJECT));
    send_word(make_point(-200000, 5, 65536, ACT_PROJECT));
    wait_idle();

    // random phases: defaults-like camera, lidar, extremes, random optics
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_cfg(32'd36323652, 32'd36323652, 32'd21004288, 32'd15761408, 1'b0);
        1: write_cfg(32'd36323652, 32'd36323652, 32'd21004288, 32'd15761408, 1'b1);
        2: write_cfg(32'd0, 32'd0, 32'd0, 32'd0, 1'b1);
        3: write_cfg(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
        default: write_cfg($urandom_range(1 << 20, 1 << 27), $urandom_range(1 << 20, 1 << 27),
                           $urandom_range(0, 640 << 16), $urandom_range(0, 480 << 16),
                           1'(($urandom)));
      endcase
      for (int i = 0; i < 125; i++) begin
        case ((i / 30) % 4)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
          default: begin send_idle_pct = 8; recv_stall_pct = 8; end
        endcase
        send_word(random_word(ph == 1 && i == 90));
      end
      wait_idle();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    $display("Sent %0d words (points, reads, clears, unused) over seven register settings,",
             words_sent);
    $display("with %0d in-frame hits; %0d errors counted.", hits_seen, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("Timeout waiting for the projector");
    $display("Test completed with failures");
    $finish;
  end
endmodule
